@@ design/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier for the Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam int unsigned QueueDepth = 2;

  // One encoded character and its end-of-message flag.
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // Request from front to back: up to three bytes, MSB byte first.
  // A count of zero with msg_end set is a bare end marker.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        msg_end;
  } cmd_t;

  // Classifier result: valid flag and six-bit value.
  typedef struct packed {
    logic       is_b64;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t classify(input logic [7:0] c);
    sextet_t r;
    r.is_b64 = 1'b1;
    r.value  = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.value = 6'd62;
    end else if (c == 8'h2f) begin
      r.value = 6'd63;
    end else begin
      r.is_b64 = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, packs sextets and posts byte-group requests.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_ready,
  input  wire b64d_pkg::in_item_t char_data,
  input  wire logic              q_full,
  output logic                   push,
  output b64d_pkg::cmd_t         cmd
);

  logic [17:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]  sextet_count, sextet_count_next;
  logic        stopped, stopped_next;

  b64d_pkg::sextet_t sx;
  logic        accept;
  logic [17:0] appended;
  logic [17:0] fb;
  logic [1:0]  fc;
  logic        do_flush;

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;
  assign sx         = b64d_pkg::classify(char_data.in_char);
  assign appended   = {sextet_buffer[11:0], sx.value};

  // Pick the group to flush, if any.
  always_comb begin
    do_flush = 1'b0;
    fb       = sextet_buffer;
    fc       = sextet_count;
    if (!stopped) begin
      if (!sx.is_b64) begin
        do_flush = 1'b1;
      end else if (sextet_count != 2'd3 && char_data.in_last) begin
        do_flush = 1'b1;
        fb       = appended;
        fc       = 2'(sextet_count + 2'd1);
      end
    end
  end

  always_comb begin
    cmd.word    = 24'd0;
    cmd.nbytes  = 2'd0;
    cmd.msg_end = char_data.in_last;
    if (!stopped && sx.is_b64 && sextet_count == 2'd3) begin
      cmd.word   = {sextet_buffer, sx.value};
      cmd.nbytes = 2'd3;
    end else if (do_flush && fc == 2'd2) begin
      cmd.word   = {fb[11:0], 12'd0};
      cmd.nbytes = 2'd1;
    end else if (do_flush && fc == 2'd3) begin
      cmd.word   = {fb, 6'd0};
      cmd.nbytes = 2'd2;
    end
  end

  assign push = accept && (cmd.nbytes != 2'd0 || char_data.in_last);

  always_comb begin
    sextet_buffer_next = sextet_buffer;
    sextet_count_next  = sextet_count;
    stopped_next       = stopped;
    if (char_data.in_last) begin
      sextet_buffer_next = 18'd0;
      sextet_count_next  = 2'd0;
      stopped_next       = 1'b0;
    end else if (!stopped) begin
      if (!sx.is_b64) begin
        stopped_next       = 1'b1;
        sextet_buffer_next = 18'd0;
        sextet_count_next  = 2'd0;
      end else if (sextet_count == 2'd3) begin
        sextet_buffer_next = 18'd0;
        sextet_count_next  = 2'd0;
      end else begin
        sextet_buffer_next = appended;
        sextet_count_next  = 2'(sextet_count + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer <= 18'd0;
      sextet_count  <= 2'd0;
      stopped       <= 1'b0;
    end else if (accept) begin
      sextet_buffer <= sextet_buffer_next;
      sextet_count  <= sextet_count_next;
      stopped       <= stopped_next;
    end
  end

endmodule

`default_nettype wire

@@ design/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64d_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output b64d_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PtrW = $clog2(b64d_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(b64d_pkg::QueueDepth + 1);

  b64d_pkg::cmd_t entries [b64d_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(b64d_pkg::QueueDepth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(b64d_pkg::QueueDepth - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(b64d_pkg::QueueDepth - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CntW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Serializes queued byte groups into registered result items.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b64d_pkg::cmd_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output b64d_pkg::out_item_t res_data
);

  logic [1:0] idx, idx_next;
  logic       load;
  logic       final_one;
  b64d_pkg::out_item_t item;

  assign load      = !empty && (!res_valid || res_ready);
  assign final_one = (head.nbytes == 2'd0) || (idx == 2'(head.nbytes - 2'd1));
  assign pop       = load && final_one;
  assign idx_next  = final_one ? 2'd0 : 2'(idx + 2'd1);

  always_comb begin
    item.byte_valid  = (head.nbytes != 2'd0);
    item.run_last    = final_one;
    item.message_end = final_one && head.msg_end;
    case (idx)
      2'd0:    item.out_byte = head.word[23:16];
      2'd1:    item.out_byte = head.word[15:8];
      default: item.out_byte = head.word[7:0];
    endcase
    if (head.nbytes == 2'd0) begin
      item.out_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= item;
    end
  end

endmodule

`default_nettype wire

@@ design/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 (standard alphabet) decoder, one character per request.
// ----------------------------------------------------------------------------
// The decoder takes one ASCII character per cycle on the char channel while
// char_ready is high and returns decoded bytes, one per cycle while res_ready
// is high, on the res channel. Four alphabet characters give three bytes; '='
// or any non-alphabet byte stops decoding and flushes a partial group (k
// pending sextets give k-1 bytes), and later characters are ignored until
// in_last. The last result of each character carries run_last, and the last
// result of a message carries message_end; a message whose final character
// yields no byte ends with a bare marker (byte_valid = 0). A character is
// taken in the cycle it arrives whenever the two-entry request queue has
// room; the front never waits on the output. The back end drains one result
// per cycle while res_ready is high, so a character that completes a group
// yields three results, and ordinary text (three bytes per four characters)
// streams at one character per cycle while res_ready stays high. A request
// passes through the queue and then the output register to its first result.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_ready,
  input  wire b64d_pkg::in_item_t  char_data,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output b64d_pkg::out_item_t      res_data
);

  // Requests between front and back.
  logic           push;
  logic           pop;
  b64d_pkg::cmd_t push_cmd;
  b64d_pkg::cmd_t head;
  logic           q_full;
  logic           q_empty;

  // Front: classify, pack sextets, post groups / end markers.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: one result per cycle into the output register while it is free.
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("request pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("request popped from empty queue");

  // A bare marker is always the end of a message and carries a zero byte.
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.byte_valid) |->
      (res_data.run_last && res_data.message_end && res_data.out_byte == 8'd0))
    else $error("malformed end marker");

  // message_end only ever closes a character's run.
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.message_end) |-> res_data.run_last)
    else $error("message_end without run_last");

endmodule

`default_nettype wire
